### sv/tap_rhythm_matcher_unit_assert.svh
// Assertion macros for the tap rhythm matcher.
// Taken in by `include from the modules that check their own logic.
`ifndef TAP_RHYTHM_MATCHER_UNIT_ASSERT_SVH
`define TAP_RHYTHM_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tap rhythm matcher: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tap rhythm matcher: next-cycle check failed");

`endif

### sv/trm_pkg.sv
// Shared types and constants of the tap rhythm matcher.
// No dependencies; imported by tap_rhythm_matcher_unit, trm_tb_pkg and tb_top.
package trm_pkg;

    // Input item kinds
    typedef enum logic {
        ACT_TAP  = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    // Register index (byte address / 8)
    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_TIMEOUT  = 3'd1,
        REG_TOLPCT   = 3'd2,
        REG_SPREAD   = 3'd3,
        REG_PATTERN  = 3'd4
    } t_reg_idx;

    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;
    localparam int TAPS_HELD_W  = 4;
    localparam int INTIME_W     = 32;
    localparam int RATIO_W      = 8;
    localparam int RATIO_COUNT  = 6;
    localparam int PATTERN_W    = RATIO_W * RATIO_COUNT;
    localparam int FACTOR_W     = 8;

    localparam logic [7:0]           PCT_FULL      = 8'd100;
    localparam logic [7:0]           IDLE_MAX      = 8'hFF;

    localparam logic                 ENABLE_RST    = 1'b0;
    localparam logic [7:0]           TIMEOUT_RST   = 8'd3;
    localparam logic [6:0]           TOLPCT_RST    = 7'd40;
    localparam logic [3:0]           SPREAD_RST    = 4'd6;
    localparam logic [PATTERN_W-1:0] PATTERN_RST   = 48'h64C864326464;

endpackage

### sv/tap_rhythm_matcher_unit.sv
// Tap rhythm matcher top level: input register, combinational rhythm check, result register.
// Depends on trm_pkg and tap_rhythm_matcher_unit_assert.svh.
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------
// input     | in        | i_valid / o_ready  | i_action, i_tap_time
// result    | out       | o_valid / i_ready  | o_matched, o_taps_held
// config    | in        | APB psel/penable   | paddr, pwdata, prdata
//
// One beat per cycle sustained while the result side is ready; a beat moves from the input
// register to the result register once that one is free or drains. The tap check (newest gap, min
// over GAP_COUNT gaps, three narrow multiplies and compares per gap) runs combinationally
// between the two registers, since the tap store it updates feeds the very next beat.
// Reset (i_rst_n low, synchronous) empties both stages and loads the register defaults.
// A stalled result holds; the input stage then fills and o_ready drops until it drains.
`include "tap_rhythm_matcher_unit_assert.svh"

module tap_rhythm_matcher_unit
    import trm_pkg::*;
#(
    parameter int TAP_DEPTH  = 8,
    parameter int GAP_COUNT  = 6,
    parameter int TIME_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_action,
    input  logic [INTIME_W-1:0]    i_tap_time,
    // result beats
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_matched,
    output logic [TAPS_HELD_W-1:0] o_taps_held,
    // APB config
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int CNT_W     = $clog2(TAP_DEPTH + 1);
    localparam int MATCH_MIN = GAP_COUNT + 1;
    localparam int PROD_W    = TIME_WIDTH + FACTOR_W;
    localparam int SPRD_W    = TIME_WIDTH + 4;

    // ---------------- config registers ----------------
    logic                   r_enable;
    logic [7:0]             r_timeout;
    logic [6:0]             r_tolpct;
    logic [3:0]             r_spread;
    logic [PATTERN_W-1:0]   r_pattern;

    t_reg_idx               w_idx;
    logic                   w_cfg_wr;

    assign w_idx    = t_reg_idx'(paddr[5:3]);
    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= ENABLE_RST;
            r_timeout <= TIMEOUT_RST;
            r_tolpct  <= TOLPCT_RST;
            r_spread  <= SPREAD_RST;
            r_pattern <= PATTERN_RST;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_ENABLE:  r_enable  <= pwdata[0];
                REG_TIMEOUT: r_timeout <= pwdata[7:0];
                REG_TOLPCT:  r_tolpct  <= pwdata[6:0];
                REG_SPREAD:  r_spread  <= pwdata[3:0];
                REG_PATTERN: r_pattern <= pwdata[PATTERN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE:  prdata = DATA_W'(r_enable);
            REG_TIMEOUT: prdata = DATA_W'(r_timeout);
            REG_TOLPCT:  prdata = DATA_W'(r_tolpct);
            REG_SPREAD:  prdata = DATA_W'(r_spread);
            REG_PATTERN: prdata = DATA_W'(r_pattern);
            default:     prdata = '0;
        endcase
    end

    // ---------------- input stage ----------------
    logic                   r_in_vld;
    t_action                r_in_action;
    logic [TIME_WIDTH-1:0]  r_in_time;
    logic                   r_out_vld;
    logic                   w_adv;

    // the input stage moves into the result register when that one is free or drains
    assign w_adv   = r_in_vld & (~r_out_vld | i_ready);
    assign o_ready = ~r_in_vld | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_action <= t_action'(i_action);
            r_in_time   <= i_tap_time[TIME_WIDTH-1:0];
        end
    end

    // ---------------- tap store ----------------
    // Only the newest timestamp and the last GAP_COUNT gaps are kept; the count says how many
    // taps the current run holds, capped at TAP_DEPTH. Index 0 is the oldest gap.
    logic [CNT_W-1:0]       r_count;
    logic [7:0]             r_idle;
    logic [TIME_WIDTH-1:0]  r_last_time;
    logic [TIME_WIDTH-1:0]  r_gap [GAP_COUNT];

    logic [CNT_W-1:0]       n_count;
    logic [7:0]             n_idle;
    logic                   n_matched;
    logic                   w_tap;
    logic [CNT_W-1:0]       w_cnt_app;
    logic [TIME_WIDTH-1:0]  w_gap [GAP_COUNT];
    logic [TIME_WIDTH-1:0]  w_min;
    logic [FACTOR_W-1:0]    w_lo_f;
    logic [FACTOR_W-1:0]    w_hi_f;
    logic                   w_reject;
    logic                   w_fits;
    logic [7:0]             w_idle_inc;

    assign w_tap     = w_adv & r_enable & (r_in_action == ACT_TAP);
    assign w_cnt_app = (32'(r_count) < TAP_DEPTH) ? r_count + 1'b1 : CNT_W'(TAP_DEPTH);

    // gaps as they stand once this tap is appended
    always_comb begin
        for (int i = 0; i < GAP_COUNT - 1; i++) begin
            w_gap[i] = r_gap[i + 1];
        end
        w_gap[GAP_COUNT-1] = r_in_time - r_last_time;
    end

    // smallest gap, short linear scan over the GAP_COUNT gap values
    always_comb begin
        w_min = w_gap[0];
        for (int i = 1; i < GAP_COUNT; i++) begin
            if (w_gap[i] < w_min) begin
                w_min = w_gap[i];
            end
        end
    end

    assign w_lo_f = (r_tolpct >= PCT_FULL[6:0] && PCT_FULL <= 8'd127) ? '0
                                                : PCT_FULL - FACTOR_W'(r_tolpct);
    assign w_hi_f = PCT_FULL + FACTOR_W'(r_tolpct);

    // per-gap spread and tolerance window; ratios past the register read as zero
    always_comb begin
        logic [SPRD_W-1:0] spread_lim;
        logic [PROD_W-1:0] target;
        logic [PROD_W-1:0] lo_side;
        logic [PROD_W-1:0] hi_side;
        logic [RATIO_W-1:0] ratio;
        spread_lim = SPRD_W'(w_min) * SPRD_W'(r_spread);
        w_reject   = (w_min == '0);
        for (int i = 0; i < GAP_COUNT; i++) begin
            ratio   = RATIO_W'(r_pattern >> (RATIO_W * i));
            if (i >= RATIO_COUNT) begin
                ratio = '0;
            end
            target  = PROD_W'(w_min) * PROD_W'(ratio);
            lo_side = PROD_W'(w_gap[i]) * PROD_W'(w_lo_f);
            hi_side = PROD_W'(w_gap[i]) * PROD_W'(w_hi_f);
            if (SPRD_W'(w_gap[i]) > spread_lim || lo_side > target || hi_side < target) begin
                w_reject = 1'b1;
            end
        end
    end

    assign w_fits     = (32'(w_cnt_app) >= MATCH_MIN) && !w_reject;
    assign w_idle_inc = (r_idle != IDLE_MAX) ? r_idle + 8'd1 : r_idle;

    always_comb begin
        n_count   = r_count;
        n_idle    = r_idle;
        n_matched = 1'b0;
        if (w_adv && r_enable) begin
            if (r_in_action == ACT_TAP) begin
                n_idle  = '0;
                n_count = w_cnt_app;
                if (w_fits) begin
                    n_matched = 1'b1;
                    n_count   = '0;
                end
            end else if (r_count != '0) begin
                n_idle = w_idle_inc;
                if (w_idle_inc >= r_timeout) begin
                    n_idle  = '0;
                    n_count = '0;
                end
            end
        end
        // an enable write empties the store whatever is written
        if (w_cfg_wr && w_idx == REG_ENABLE) begin
            n_count = '0;
            n_idle  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idle  <= '0;
        end else begin
            r_count <= n_count;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tap) begin
            r_last_time <= r_in_time;
            if (r_count != '0) begin
                for (int i = 0; i < GAP_COUNT; i++) begin
                    r_gap[i] <= w_gap[i];
                end
            end
        end
    end

    // ---------------- result stage ----------------
    logic                   r_matched;
    logic [TAPS_HELD_W-1:0] r_taps_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_matched   <= n_matched;
            r_taps_held <= TAPS_HELD_W'(n_count);
        end
    end

    assign o_valid     = r_out_vld;
    assign o_matched   = r_matched;
    assign o_taps_held = r_taps_held;

    // ---------------- checks ----------------
    `TRM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= TAP_DEPTH)
    `TRM_ASSERT_NOW(a_idle_needs_taps, i_clk, i_rst_n, r_idle != '0, r_count != '0)
    `TRM_ASSERT_NOW(a_match_empties, i_clk, i_rst_n, r_out_vld && r_matched, r_taps_held == '0)
    `TRM_ASSERT_NEXT(a_off_no_match, i_clk, i_rst_n, w_adv && !r_enable, !r_matched)

endmodule

### bench/trm_tb_pkg.sv
`timescale 1ns / 100ps
// Knock tracker: predicts the result of every beat taken by the tap rhythm matcher and checks it.
// Depends on trm_pkg for the action and register codes and the port widths.
package trm_tb_pkg;
    import trm_pkg::*;

    localparam int STORE_DEPTH = 8;
    localparam int GAPS        = 6;

    typedef struct packed {
        logic                   matched;
        logic [TAPS_HELD_W-1:0] taps_held;
    } t_knock_result;

    class knock_tracker;
        bit                   enable;
        bit [7:0]             timeout_s;
        bit [6:0]             tol_pct;
        bit [3:0]             spread;
        bit [PATTERN_W-1:0]   pattern;
        bit [INTIME_W-1:0]    stamps [STORE_DEPTH];
        int unsigned          held;
        int unsigned          idle_s;
        t_knock_result        results_due [$];
        int unsigned          mismatches;

        function new();
            enable     = ENABLE_RST;
            timeout_s  = TIMEOUT_RST;
            tol_pct    = TOLPCT_RST;
            spread     = SPREAD_RST;
            pattern    = PATTERN_RST;
            held       = 0;
            idle_s     = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ENABLE: begin
                    // any write to enable empties the store
                    enable = value[0];
                    held   = 0;
                    idle_s = 0;
                end
                REG_TIMEOUT: timeout_s = value[7:0];
                REG_TOLPCT:  tol_pct   = value[6:0];
                REG_SPREAD:  spread    = value[3:0];
                REG_PATTERN: pattern   = value[PATTERN_W-1:0];
                default: ;
            endcase
        endfunction

        // Newest seven stamps against the ratio pattern; all products at 64 bits.
        function bit gaps_fit_pattern();
            bit [63:0]          gap [GAPS];
            bit [63:0]          least;
            bit [63:0]          lo_f;
            bit [63:0]          hi_f;
            bit [63:0]          target;
            bit [INTIME_W-1:0]  diff;
            int unsigned        first;
            int                 g;
            if (held < GAPS + 1) begin
                return 1'b0;
            end
            first = held - (GAPS + 1);
            least = 0;
            for (g = 0; g < GAPS; g++) begin
                diff   = stamps[first + g + 1] - stamps[first + g];
                gap[g] = 64'(diff);
                if (g == 0 || gap[g] < least) begin
                    least = gap[g];
                end
            end
            if (least == 0) begin
                return 1'b0;
            end
            for (g = 0; g < GAPS; g++) begin
                if (gap[g] > least * spread) begin
                    return 1'b0;
                end
            end
            lo_f = (tol_pct >= PCT_FULL) ? 64'd0 : 64'(PCT_FULL - tol_pct);
            hi_f = 64'(PCT_FULL) + 64'(tol_pct);
            for (g = 0; g < GAPS; g++) begin
                target = least * pattern[RATIO_W*g +: RATIO_W];
                if (gap[g] * lo_f > target || gap[g] * hi_f < target) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void log_beat(t_action act, logic [INTIME_W-1:0] stamp);
            t_knock_result r;
            int            k;
            r.matched = 1'b0;
            if (enable) begin
                if (act == ACT_TAP) begin
                    if (held < STORE_DEPTH) begin
                        stamps[held] = stamp;
                        held++;
                    end else begin
                        for (k = 0; k < STORE_DEPTH - 1; k++) begin
                            stamps[k] = stamps[k + 1];
                        end
                        stamps[STORE_DEPTH - 1] = stamp;
                    end
                    idle_s = 0;
                    if (gaps_fit_pattern()) begin
                        r.matched = 1'b1;
                        held      = 0;
                        idle_s    = 0;
                    end
                end else if (held != 0) begin
                    if (idle_s < IDLE_MAX) begin
                        idle_s++;
                    end
                    if (idle_s >= timeout_s) begin
                        held   = 0;
                        idle_s = 0;
                    end
                end
            end
            r.taps_held = TAPS_HELD_W'(held);
            results_due.push_back(r);
        endfunction

        function void compare_result(logic matched, logic [TAPS_HELD_W-1:0] taps_held);
            t_knock_result want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result beat: matched %0d taps_held %0d",
                         $time, matched, taps_held);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (matched !== want.matched) begin
                $display("%0t: matched expected %0d actual %0d", $time, want.matched, matched);
                mismatches++;
            end
            if (taps_held !== want.taps_held) begin
                $display("%0t: taps_held expected %0d actual %0d",
                         $time, want.taps_held, taps_held);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for tap_rhythm_matcher_unit: clock, reset, tap/tick beat driver, APB writes, phases.
// Depends on trm_pkg, trm_tb_pkg (knock_tracker) and the matcher RTL.
module tb_top;
    import trm_pkg::*;
    import trm_tb_pkg::*;

    // beat in -> result out is two register stages
    localparam int PIPE_LATENCY  = 2;
    localparam int SETTLE_CYCLES = 8;
    // a correct run stays well under this limit even with heavy stalls
    localparam int CYCLE_LIMIT   = 400000;
    // ratio menu for patterns that real knocks can hit
    localparam int RATIO_STEPS [6] = '{100, 100, 125, 150, 200, 250};

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic                   i_action    = ACT_TAP;
    logic [INTIME_W-1:0]    i_tap_time  = '0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic                   o_matched;
    logic [TAPS_HELD_W-1:0] o_taps_held;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [ADDR_W-1:0]      paddr       = '0;
    logic [DATA_W-1:0]      pwdata      = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    knock_tracker           tracker;
    int unsigned            send_idle_pct;   // chance per cycle that the sender holds off
    int unsigned            recv_stall_pct;  // chance per cycle that i_ready is low
    logic [INTIME_W-1:0]    beat_clock;      // running tap time, so knocks move forward
    int unsigned            cycle_count;

    tap_rhythm_matcher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_tap_time  (i_tap_time),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_matched   (o_matched),
        .o_taps_held (o_taps_held),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result-side backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Both handshakes are sampled here, before this edge's updates land.
    // A beat is logged before any result of the same edge is checked; results
    // trail their beats through both register stages, so the order never matters.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tracker.log_beat(t_action'(i_action), i_tap_time);
            end
            if (o_valid && i_ready) begin
                tracker.compare_result(o_matched, o_taps_held);
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 60;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 60;
            end
            default: begin
                send_idle_pct  = 17;
                recv_stall_pct = 17;
            end
        endcase
    endtask

    // One beat; returns at the edge that takes it. Valid only drops when a gap is drawn,
    // so back-to-back beats never lower and raise valid in one step.
    task automatic send_beat(input t_action act, input logic [INTIME_W-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_tap_time <= stamp;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // Hold off until every predicted result has come back, then let the pipe settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access; back-to-back writes go straight from access to the next setup.
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        tracker.write_reg(idx, value);
    endtask

    task automatic configure(input bit en, input bit [7:0] secs, input bit [6:0] pct,
                             input bit [3:0] spread, input bit [PATTERN_W-1:0] ratios);
        apb_write(REG_PATTERN, DATA_W'(ratios));
        apb_write(REG_SPREAD,  DATA_W'(spread));
        apb_write(REG_TOLPCT,  DATA_W'(pct));
        apb_write(REG_TIMEOUT, DATA_W'(secs));
        apb_write(REG_ENABLE,  DATA_W'(en));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Pattern whose smallest ratio is exactly 100, so evenly scaled knocks can match.
    function automatic logic [PATTERN_W-1:0] knock_pattern();
        logic [PATTERN_W-1:0] p;
        int                   g;
        int                   anchor;
        for (g = 0; g < GAPS; g++) begin
            p[RATIO_W*g +: RATIO_W] = RATIO_W'(RATIO_STEPS[$urandom_range(0, 5)]);
        end
        anchor = $urandom_range(0, GAPS - 1);
        p[RATIO_W*anchor +: RATIO_W] = 8'd100;
        return p;
    endfunction

    // Seven taps spaced by the current pattern, sometimes jittered, broken, interrupted
    // by a tick, preceded by stray taps, or laid across the timestamp wrap.
    task automatic send_knock(output int unsigned beats);
        logic [63:0]         base_gap;
        logic [63:0]         stretch;
        logic [63:0]         wobble;
        logic [INTIME_W-1:0] gap_len [GAPS];
        logic [INTIME_W-1:0] total;
        logic [INTIME_W-1:0] stamp;
        int                  tick_at;
        int                  lead;
        int                  g;
        beats = 0;
        case ($urandom_range(0, 3))
            0: base_gap = 64'(100 * $urandom_range(1, 40));    // exact before jitter, holds at zero tolerance
            1: base_gap = 64'($urandom_range(1, 500));
            2: base_gap = 64'($urandom_range(1, 8));
            default: base_gap = 64'($urandom_range(1000, 32'h0400_0000));
        endcase
        for (g = 0; g < GAPS; g++) begin
            stretch = (base_gap * tracker.pattern[RATIO_W*g +: RATIO_W]) / 100;
            wobble  = stretch / 16;
            if (wobble != 0 && $urandom_range(0, 1) == 1) begin
                stretch = stretch - wobble + 64'($urandom_range(0, 32'(2 * wobble)));
            end
            gap_len[g] = stretch[INTIME_W-1:0];
        end
        if ($urandom_range(0, 9) == 0) begin
            gap_len[$urandom_range(0, GAPS - 1)] = $urandom();
        end
        total = 0;
        for (g = 0; g < GAPS; g++) begin
            total += gap_len[g];
        end
        tick_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, GAPS) : -1;
        if ($urandom_range(0, 3) == 0) begin
            stamp = 32'hFFFF_FFFF - $urandom_range(0, total);
        end else begin
            stamp = beat_clock + $urandom_range(1, 2000);
        end
        lead = $urandom_range(0, 2);
        repeat (lead) begin
            send_beat(ACT_TAP, $urandom());
            beats++;
        end
        for (g = 0; g <= GAPS; g++) begin
            if (g == tick_at) begin
                send_beat(ACT_TICK, $urandom());
                beats++;
            end
            send_beat(ACT_TAP, stamp);
            beats++;
            if (g < GAPS) begin
                stamp += gap_len[g];
            end
        end
        beat_clock = stamp;
    endtask

    // Mostly knocks; the rest stray taps, single ticks, tick runs that can hit the timeout, and rare drains.
    task automatic run_phase(input int unsigned target);
        int unsigned         done;
        int unsigned         n;
        int unsigned         pick;
        logic [INTIME_W-1:0] stamp;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_knock(n);
                done += n;
            end else if (pick < 75) begin
                if ($urandom_range(0, 1) == 1) begin
                    stamp = $urandom();
                end else begin
                    stamp = beat_clock + $urandom_range(0, 300);
                end
                send_beat(ACT_TAP, stamp);
                beat_clock = stamp;
                done++;
            end else if (pick < 99) begin
                n = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : 1;
                repeat (n) send_beat(ACT_TICK, $urandom());
                done += n;
            end else begin
                // sender goes quiet until the pipe is empty
                wait_drained();
            end
        end
    endtask

    initial begin
        int k;
        int phase;
        tracker = new();
        set_idling(0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the detector is off: both kinds of beat leave the store empty.
        send_beat(ACT_TAP, 32'hFFFF_FFFF);
        send_beat(ACT_TICK, 32'h0000_0000);
        wait_drained();

        configure(1'b1, 8'd3, 7'd40, 4'd6, {GAPS{8'd100}});
        // tick on an empty store is a no-op
        send_beat(ACT_TICK, 32'h5A5A_A5A5);
        // even knock straddling the 32-bit wrap; the seventh tap matches and clears
        for (k = 0; k < 7; k++) begin
            send_beat(ACT_TAP, 32'hFFFF_FFE0 + 10 * k);
        end
        // all-zero gaps never match; the ninth tap pushes the oldest out of a full store
        for (k = 0; k < 9; k++) begin
            send_beat(ACT_TAP, 32'h0000_0000);
        end
        // third idle second reaches the timeout and drops the taps
        for (k = 0; k < 3; k++) begin
            send_beat(ACT_TICK, 32'hFFFF_FFFF);
        end
        beat_clock = 0;

        // Random phases, each with its own register set and idling mode.
        for (phase = 0; phase < 9; phase++) begin
            wait_drained();
            case (phase)
                0: configure(1'b1, 8'd3, 7'd40, 4'd6, knock_pattern());
                1: configure(1'b1, 8'd255, 7'd0, 4'd15, knock_pattern());
                2: configure(1'b1, 8'd1, 7'd99, 4'd1, knock_pattern());
                // zero timeout, tolerance past 100, zero spread
                3: configure(1'b1, 8'd0, 7'd127, 4'd0, knock_pattern());
                4: configure(1'b1, 8'($urandom_range(1, 8)), 7'($urandom_range(0, 127)),
                             4'($urandom_range(0, 15)), PATTERN_W'({$urandom(), $urandom()}));
                // detector off: everything passes through untouched
                5: configure(1'b0, 8'd5, 7'd20, 4'd6, knock_pattern());
                6: configure(1'b1, 8'd2, 7'd10, 4'd3, knock_pattern());
                7: configure(1'b1, 8'd4, 7'd99, 4'd15, {PATTERN_W{1'b1}});
                default: configure(1'b1, 8'($urandom_range(1, 6)), 7'($urandom_range(0, 60)),
                                   4'($urandom_range(2, 15)), knock_pattern());
            endcase
            set_idling(phase % 4);
            run_phase((phase == 5) ? 30 : 115);
        end

        wait_drained();
        if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
